FILE: rtl/escbc_pkg.sv
// Shared types, constants and the segment base table of the ECC syndrome bit corrector.
package escbc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int WORD_W   = 32;
   localparam int SEL_W    = 10;
   localparam int POS_W    = 9;
   localparam int OFFSET_W = 9;
   localparam int MASK_W   = 8;
   localparam int TAG_W    = 5;
   localparam int INDEX_W  = 11;

   localparam logic [TAG_W-1:0] TAG_LENGTH_RESET = 5'd16;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_DATA = 2'd1,
      ACT_TAG  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CLS_SKIP = 2'd0,
      CLS_BAD  = 2'd1,
      CLS_DATA = 2'd2,
      CLS_TAG  = 2'd3
   } class_type;

   typedef struct packed {
      class_type             kind;
      logic [OFFSET_W-1:0]   byte_offset;
      logic [MASK_W-1:0]     flip_mask;
      logic                  last_word;
   } entry_type;

   function automatic logic signed [INDEX_W-1:0] segment_base(input logic [2:0] pair);
      logic signed [INDEX_W-1:0] base;
      begin
         case (pair)
            3'd0: base = -11'sd112;
            3'd1: base = 11'sd16;
            3'd2: base = 11'sd144;
            3'd3: base = 11'sd272;
            3'd4: base = 11'sd400;
            default: base = '0;
         endcase
         return base;
      end
   endfunction

endpackage

FILE: rtl/escbc_if.sv
// Request and response channel interfaces of the ECC syndrome bit corrector.
interface escbc_req_if;
   logic                           valid;
   logic                           ready;
   logic [escbc_pkg::WORD_W-1:0]   location_word;
   logic                           last_word;

   modport source (output valid, output location_word, output last_word, input ready);
   modport sink (input valid, input location_word, input last_word, output ready);
endinterface

interface escbc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      action;
   logic [escbc_pkg::OFFSET_W-1:0]  byte_offset;
   logic [escbc_pkg::MASK_W-1:0]    flip_mask;
   logic                            batch_done;
   logic                            batch_failed;

   modport source (output valid, output action, output byte_offset, output flip_mask,
                   output batch_done, output batch_failed, input ready);
   modport sink (input valid, input action, input byte_offset, input flip_mask,
                 input batch_done, input batch_failed, output ready);
endinterface

FILE: rtl/escbc_front.sv
// Front end: accepts location words and classifies them into queue entries.
module escbc_front (
   escbc_req_if.sink                       req_bus,
   input  logic [escbc_pkg::TAG_W-1:0]     tag_length,
   input  logic                            queue_ready,
   output logic                            push,
   output escbc_pkg::entry_type            push_entry
);

   logic [escbc_pkg::SEL_W-1:0]             sel;
   logic [escbc_pkg::POS_W-1:0]             pos;
   logic                                    sel_onehot;
   logic [3:0]                              seg_idx;
   logic signed [escbc_pkg::INDEX_W-1:0]    base;
   logic signed [escbc_pkg::INDEX_W-1:0]    bit_pos;
   logic signed [escbc_pkg::INDEX_W-1:0]    byte_index;
   logic                                    tag_ok;

   assign req_bus.ready = queue_ready;
   assign push = req_bus.valid && queue_ready;

   assign sel = req_bus.location_word[18:9];
   assign pos = req_bus.location_word[8:0];
   assign sel_onehot = (sel != '0) && ((sel & (sel - 1'b1)) == '0);

   always_comb begin
      seg_idx = '0;
      for (int k = 0; k < escbc_pkg::SEL_W; k++) begin
         if (sel[k]) begin
            seg_idx = 4'(k);
         end
      end
   end

   assign base = escbc_pkg::segment_base(seg_idx[3:1]);
   assign bit_pos = $signed({1'b0, pos, seg_idx[0]}) - 11'sd4;
   assign byte_index = base + (bit_pos >>> 3);
   assign tag_ok = (byte_index[8:4] == '0) && ({1'b0, byte_index[3:0]} < tag_length);

   always_comb begin
      push_entry.kind = escbc_pkg::CLS_SKIP;
      push_entry.byte_offset = '0;
      push_entry.flip_mask = '0;
      push_entry.last_word = req_bus.last_word;
      if (req_bus.location_word != '0) begin
         if (!sel_onehot || byte_index[10]) begin
            push_entry.kind = escbc_pkg::CLS_BAD;
         end else if (!byte_index[9]) begin
            push_entry.kind = escbc_pkg::CLS_DATA;
            push_entry.byte_offset = byte_index[8:0];
            push_entry.flip_mask = 8'h80 >> bit_pos[2:0];
         end else if (tag_ok) begin
            push_entry.kind = escbc_pkg::CLS_TAG;
            push_entry.byte_offset = {5'd0, byte_index[3:0]};
            push_entry.flip_mask = 8'h80 >> bit_pos[2:0];
         end else begin
            push_entry.kind = escbc_pkg::CLS_BAD;
         end
      end
   end

endmodule

FILE: rtl/escbc_queue.sv
// Short queue of classified entries between the front and back ends.
module escbc_queue #(
   parameter int DEPTH = escbc_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  escbc_pkg::entry_type   push_entry,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   head_valid,
   output escbc_pkg::entry_type   head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   escbc_pkg::entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/escbc_back.sv
// Back end: tracks batch state and drives the registered flip command response.
module escbc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  escbc_pkg::entry_type   head_entry,
   output logic                   pop,
   escbc_rsp_if.source            rsp_bus
);

   logic                               rsp_valid_ff;
   logic                               aborted_ff, aborted_in;
   logic                               applied_ff, applied_in;
   escbc_pkg::action_type              action_ff, action_in;
   logic [escbc_pkg::OFFSET_W-1:0]     offset_ff, offset_in;
   logic [escbc_pkg::MASK_W-1:0]       mask_ff, mask_in;
   logic                               done_ff;
   logic                               failed_ff, failed_in;

   assign pop = head_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      action_in = escbc_pkg::ACT_NONE;
      offset_in = '0;
      mask_in = '0;
      aborted_in = aborted_ff;
      applied_in = applied_ff;
      failed_in = 1'b0;
      if (!aborted_ff) begin
         case (head_entry.kind)
            escbc_pkg::CLS_BAD: begin
               aborted_in = 1'b1;
            end
            escbc_pkg::CLS_DATA: begin
               action_in = escbc_pkg::ACT_DATA;
               offset_in = head_entry.byte_offset;
               mask_in = head_entry.flip_mask;
               applied_in = 1'b1;
            end
            escbc_pkg::CLS_TAG: begin
               action_in = escbc_pkg::ACT_TAG;
               offset_in = head_entry.byte_offset;
               mask_in = head_entry.flip_mask;
               applied_in = 1'b1;
            end
            default: begin
               action_in = escbc_pkg::ACT_NONE;
            end
         endcase
      end
      if (head_entry.last_word) begin
         failed_in = aborted_in || !applied_in;
         aborted_in = 1'b0;
         applied_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         aborted_ff <= 1'b0;
         applied_ff <= 1'b0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            aborted_ff <= aborted_in;
            applied_ff <= applied_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff <= action_in;
         offset_ff <= offset_in;
         mask_ff <= mask_in;
         done_ff <= head_entry.last_word;
         failed_ff <= failed_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.action = action_ff;
   assign rsp_bus.byte_offset = offset_ff;
   assign rsp_bus.flip_mask = mask_ff;
   assign rsp_bus.batch_done = done_ff;
   assign rsp_bus.batch_failed = failed_ff;

   a_cmd_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (action_ff != escbc_pkg::ACT_NONE) |-> $onehot(mask_ff))
      else $error("flip command without a one-hot mask");

   a_idle_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (action_ff == escbc_pkg::ACT_NONE) |-> (offset_ff == '0) && (mask_ff == '0))
      else $error("empty command carries an offset or a mask");

   a_failed_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !done_ff |-> !failed_ff)
      else $error("failure reported before the end of a batch");

   a_state_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.last_word |=> !aborted_ff && !applied_ff)
      else $error("batch state not cleared after the last request");

endmodule

FILE: rtl/ecc_syndrome_bit_corrector_unit.sv
// Top level of the ECC syndrome bit corrector.
// Each request passes through a queue slot and then the back-end response register.
// Throughput: one request per cycle unless rsp_bus.ready stalls the response register.
// The queue between front and back end holds QUEUE_DEPTH classified requests.
// Reset clears the queue, the batch flags and the response valid, and sets tag_length to 16.
module ecc_syndrome_bit_corrector_unit #(
   parameter int QUEUE_DEPTH = escbc_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   escbc_req_if.sink                     req_bus,
   escbc_rsp_if.source                   rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [escbc_pkg::TAG_W-1:0]   csr_wr_data
);

   logic [escbc_pkg::TAG_W-1:0]   tag_length_ff;
   logic                          queue_ready;
   logic                          push;
   escbc_pkg::entry_type          push_entry;
   logic                          pop;
   logic                          head_valid;
   escbc_pkg::entry_type          head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_length_ff <= escbc_pkg::TAG_LENGTH_RESET;
      end else if (csr_wr_en) begin
         tag_length_ff <= csr_wr_data;
      end
   end

   escbc_front u_front (
      .req_bus     (req_bus),
      .tag_length  (tag_length_ff),
      .queue_ready (queue_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   escbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   escbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: dv/escbc_flip_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the flip commands of the ECC syndrome bit corrector and compares the responses.
module escbc_flip_checker (
   input  logic                          clock,
   input  logic                          reset,
   escbc_req_if                          req_bus,
   escbc_rsp_if                          rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [escbc_pkg::TAG_W-1:0]   csr_wr_data,
   output int                            fail_count,
   output int                            pending_count
);

   typedef struct packed {
      escbc_pkg::action_type                 action;
      logic [escbc_pkg::OFFSET_W-1:0]        byte_offset;
      logic [escbc_pkg::MASK_W-1:0]          flip_mask;
      logic                                  batch_done;
      logic                                  batch_failed;
   } flip_cmd_type;

   flip_cmd_type                      flips_due[$];
   logic [escbc_pkg::TAG_W-1:0]       tag_len;
   logic                              batch_aborted;
   logic                              batch_applied;

   function automatic flip_cmd_type predict_flip(input logic [escbc_pkg::WORD_W-1:0] word,
                                                 input logic last);
      flip_cmd_type                   cmd;
      logic [escbc_pkg::SEL_W-1:0]    sel;
      logic           well_formed;
      int             seg;
      int             base;
      int             bit_pos;
      int             idx;
      cmd = '0;
      if (!batch_aborted && word != '0) begin
         sel = word[18:9];
         well_formed = (sel != '0) && ((sel & (sel - 10'd1)) == '0);
         seg = 0;
         for (int k = 0; k < escbc_pkg::SEL_W; k++) begin
            if (sel[k]) begin
               seg = k;
            end
         end
         // Each pair of selector bits shares a segment; the odd member is one bit further on.
         base = 128 * (seg / 2) - 112;
         bit_pos = 2 * int'(word[8:0]) + (seg % 2) - 4;
         if (bit_pos < 0) begin
            bit_pos += 8;
            base -= 1;
         end
         idx = base + bit_pos / 8;
         if (!well_formed || idx < 0) begin
            batch_aborted = 1'b1;
         end else if (idx < 512) begin
            cmd.action = escbc_pkg::ACT_DATA;
            cmd.byte_offset = idx[escbc_pkg::OFFSET_W-1:0];
            cmd.flip_mask = 8'h80 >> (bit_pos % 8);
            batch_applied = 1'b1;
         end else if (idx - 512 < int'(tag_len)) begin
            idx -= 512;
            cmd.action = escbc_pkg::ACT_TAG;
            cmd.byte_offset = idx[escbc_pkg::OFFSET_W-1:0];
            cmd.flip_mask = 8'h80 >> (bit_pos % 8);
            batch_applied = 1'b1;
         end else begin
            batch_aborted = 1'b1;
         end
      end
      if (last) begin
         cmd.batch_done = 1'b1;
         cmd.batch_failed = batch_aborted || !batch_applied;
         batch_aborted = 1'b0;
         batch_applied = 1'b0;
      end
      return cmd;
   endfunction

   task automatic check_field(input string name, input logic [escbc_pkg::OFFSET_W-1:0] want_v,
                              input logic [escbc_pkg::OFFSET_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      flip_cmd_type want;
      if (reset) begin
         tag_len = escbc_pkg::TAG_LENGTH_RESET;
         batch_aborted = 1'b0;
         batch_applied = 1'b0;
         flips_due.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            tag_len = csr_wr_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            flips_due.push_back(predict_flip(req_bus.location_word, req_bus.last_word));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (flips_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got action %0d offset 0x%0h",
                        $time, rsp_bus.action, rsp_bus.byte_offset);
               fail_count++;
            end else begin
               want = flips_due.pop_front();
               check_field("action", 9'(want.action), 9'(rsp_bus.action));
               check_field("byte_offset", want.byte_offset, rsp_bus.byte_offset);
               check_field("flip_mask", 9'(want.flip_mask), 9'(rsp_bus.flip_mask));
               check_field("batch_done", 9'(want.batch_done), 9'(rsp_bus.batch_done));
               check_field("batch_failed", 9'(want.batch_failed), 9'(rsp_bus.batch_failed));
            end
         end
      end
      pending_count = flips_due.size();
   end

endmodule

FILE: dv/tb_ecc_syndrome_bit_corrector_unit.sv
`timescale 1ns / 100ps
// Top of the testbench: drives error-location requests and register writes, and gives the verdict.
module tb_ecc_syndrome_bit_corrector_unit;

   localparam int CYCLE_LIMIT = 200000;
   localparam int BATCHES_PER_PHASE = 20;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [escbc_pkg::TAG_W-1:0]   csr_wr_data = '0;
   int                            fail_count;
   int                            pending_count;
   int                            cycle_count = 0;
   int                            burst_left = 0;
   int                            mode_left = 0;
   stall_style_type               stall_style = STALL_NONE;
   logic [escbc_pkg::TAG_W-1:0]   tag_settings [6] = '{5'd0, 5'd31, 5'd1, 5'd9, 5'd16, 5'd15};

   escbc_req_if req_bus ();
   escbc_rsp_if rsp_bus ();

   ecc_syndrome_bit_corrector_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   escbc_flip_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_style)
         STALL_NONE: begin
            rsp_bus.ready <= 1'b1;
         end
         STALL_LIGHT: begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
         STALL_PERIODIC: begin
            rsp_bus.ready <= (cycle_count % 5 == 0);
         end
         default: begin
            rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   function automatic logic [escbc_pkg::WORD_W-1:0] make_location_word();
      int                            pick;
      int                            a;
      int                            b;
      logic [escbc_pkg::SEL_W-1:0]   sel;
      logic [escbc_pkg::POS_W-1:0]   pos;
      logic [12:0]                   upper;
      pick = $urandom_range(0, 99);
      upper = 13'($urandom);
      pos = 9'($urandom);
      a = $urandom_range(0, 9);
      sel = 10'd1 << a;
      if (pick < 12) begin
         return '0;
      end
      if (pick < 70) begin
         if (a < 2) begin
            pos = 9'($urandom_range(450, 511));
         end
      end else if (pick < 82) begin
         b = (a + $urandom_range(1, 9)) % 10;
         sel = sel | (10'd1 << b) | (10'($urandom) & 10'($urandom));
      end else if (pick < 90) begin
         sel = '0;
         pos = 9'($urandom_range(1, 511));
      end else begin
         sel = 10'd1 << $urandom_range(0, 1);
         pos = 9'($urandom_range(0, 400));
      end
      return {upper, sel, pos};
   endfunction

   task automatic push_word(input logic [escbc_pkg::WORD_W-1:0] word, input logic last);
      int gaps;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gaps = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         for (int k = 0; k < gaps; k++) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.location_word <= word;
      req_bus.last_word <= last;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_tag_length(input logic [escbc_pkg::TAG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_batches(input int count);
      int len;
      for (int n = 0; n < count; n++) begin
         len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
         for (int k = 0; k < len; k++) begin
            push_word(make_location_word(), k == len - 1);
         end
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.location_word = '0;
      req_bus.last_word = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_tag_length(5'd16);

      // An empty batch, then data and tag flips at the far ends of both areas.
      push_word(32'h0000_0000, 1'b1);
      push_word(32'h0000_03C2, 1'b0);
      push_word(32'hFFFC_01FF, 1'b0);
      push_word(32'h0000_0000, 1'b0);
      push_word(32'h0004_0000, 1'b1);
      // A selector that is not one-hot aborts, and later good requests are ignored.
      push_word(32'h0007_FFFF, 1'b0);
      push_word(32'h0000_03C2, 1'b0);
      push_word(32'h0000_03C2, 1'b1);
      push_word(32'h0000_0200, 1'b1);
      push_word(32'h8000_0000, 1'b1);
      for (int k = 0; k < escbc_pkg::SEL_W; k++) begin
         push_word((32'd1 << (9 + k)) | 32'd480, k == escbc_pkg::SEL_W - 1);
      end
      drain();

      foreach (tag_settings[p]) begin
         set_tag_length(tag_settings[p]);
         if (tag_settings[p] == 5'd0) begin
            push_word(32'hFFFC_01FF, 1'b0);
            push_word(32'h0000_03C2, 1'b1);
         end
         random_batches(BATCHES_PER_PHASE);
         drain();
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
